[hw/rtl/sdb_pkg.sv]
// shared types and constants for the segment dispatch buffer
package sdb_pkg;

	localparam int SIZE_W  = 24;
	localparam int ID_W    = 16;
	localparam int TOTAL_W = 30;
	localparam int LIMIT_W = 7;
	localparam int DELAY_W = 8;
	localparam int CFG_W   = 30;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIST_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DELAY_CAP  = 2'd2;

	localparam logic [TOTAL_W-1:0] SIZE_LIMIT_RST = 30'd10485760;
	localparam logic [LIMIT_W-1:0] LIST_LIMIT_RST = 7'd32;
	localparam logic [DELAY_W-1:0] DELAY_CAP_RST  = 8'd30;

	localparam logic FUNC_ARRIVE = 1'b0;
	localparam logic FUNC_IDLE   = 1'b1;

	typedef struct packed {
		logic              func;
		logic [ID_W-1:0]   segment_id;
		logic [SIZE_W-1:0] segment_size;
	} sdb_in_t;

	typedef struct packed {
		logic               dispatch_valid;
		logic [ID_W-1:0]    dispatch_id;
		logic [SIZE_W-1:0]  dispatch_size;
		logic               buffer_full;
		logic [DELAY_W-1:0] delay_seconds;
		logic               dropped;
	} sdb_out_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [SIZE_W-1:0] size;
	} sdb_entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_LOAD
	} sdb_state_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic issue_read;
		logic commit_direct;
		logic commit_pop;
	} sdb_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pop_pending;
		logic out_free;
	} sdb_stat_t;

endpackage

[hw/rtl/sdb_ctrl.sv]
// controller state machine for the segment dispatch buffer
module sdb_ctrl import sdb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      seg_valid,
	output logic      seg_stall,
	input  sdb_stat_t stat,
	output sdb_cmd_t  cmd
);

	sdb_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (seg_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (stat.pop_pending) begin
					state_d = ST_LOAD;
				end else if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_LOAD: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		seg_stall = 1'b1;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				seg_stall   = 1'b0;
				cmd.capture = seg_valid;
			end
			ST_EXEC: begin
				cmd.issue_read    = stat.pop_pending;
				cmd.commit_direct = !stat.pop_pending && stat.out_free;
			end
			ST_LOAD: begin
				cmd.commit_pop = stat.out_free;
			end
			default: begin
				seg_stall = 1'b1;
			end
		endcase
	end

endmodule

[hw/rtl/sdb_datapath.sv]
// queue memory, byte total, backpressure evaluation and result register
module sdb_datapath import sdb_pkg::*; #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sdb_in_t              seg,
	input  sdb_cmd_t             cmd,
	output sdb_stat_t            stat,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output logic                 res_valid,
	input  logic                 res_stall,
	output sdb_out_t             res
);

	localparam int PW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW   = $clog2(QUEUE_DEPTH + 1);
	localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;

	sdb_entry_t mem [QUEUE_DEPTH];
	sdb_entry_t rd_q;

	sdb_in_t            item_q;
	logic [TOTAL_W-1:0] size_limit_q;
	logic [LIMIT_W-1:0] list_limit_q;
	logic [DELAY_W-1:0] delay_cap_q;
	logic               dec_idle_q;
	logic [TOTAL_W-1:0] total_q;
	logic [PW-1:0]      head_q;
	logic [PW-1:0]      tail_q;
	logic [CW-1:0]      count_q;
	logic               full_q;
	logic [DELAY_W-1:0] delay_q;
	logic               res_valid_q;
	sdb_out_t           res_q;

	logic               arrive;
	logic               fifo_full;
	logic               push;
	logic               drop;
	logic [TOTAL_W:0]   sum;
	logic [TOTAL_W-1:0] total_d;
	logic [CW-1:0]      count_d;
	logic               full_eval;
	logic [DELAY_W:0]   delay_inc;
	logic [DELAY_W-1:0] delay_eval;
	logic               do_eval;
	logic               out_free;
	sdb_out_t           result;

	assign arrive    = (item_q.func == FUNC_ARRIVE);
	assign fifo_full = (count_q == CW'(QUEUE_DEPTH));
	assign push      = cmd.commit_direct && arrive && !dec_idle_q && !fifo_full;
	assign drop      = cmd.commit_direct && arrive && !dec_idle_q && fifo_full;
	assign out_free  = !res_valid_q || !res_stall;

	assign stat.pop_pending = (item_q.func == FUNC_IDLE) && (count_q != '0);
	assign stat.out_free    = out_free;

	// next byte total and count
	always_comb begin
		sum     = {1'b0, total_q} + (TOTAL_W + 1)'(item_q.segment_size);
		total_d = total_q;
		count_d = count_q;
		if (push) begin
			total_d = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
			count_d = count_q + CW'(1);
		end else if (cmd.commit_pop) begin
			total_d = (total_q >= TOTAL_W'(rd_q.size))
				? total_q - TOTAL_W'(rd_q.size) : '0;
			count_d = count_q - CW'(1);
		end
	end

	// backpressure evaluation on the updated totals
	always_comb begin
		full_eval  = (total_d > size_limit_q) || (CMPW'(count_d) > CMPW'(list_limit_q));
		delay_inc  = {1'b0, delay_q} + (DELAY_W + 1)'(1);
		delay_eval = '0;
		if (full_eval) begin
			delay_eval = (delay_inc < {1'b0, delay_cap_q})
				? delay_inc[DELAY_W-1:0] : delay_cap_q;
		end
		do_eval = (cmd.commit_direct && arrive) || cmd.commit_pop;
	end

	always_comb begin
		result               = '0;
		result.buffer_full   = do_eval ? full_eval : full_q;
		result.delay_seconds = do_eval ? delay_eval : delay_q;
		result.dropped       = drop;
		if (cmd.commit_pop) begin
			result.dispatch_valid = 1'b1;
			result.dispatch_id    = rd_q.id;
			result.dispatch_size  = rd_q.size;
		end else if (cmd.commit_direct && arrive && dec_idle_q) begin
			result.dispatch_valid = 1'b1;
			result.dispatch_id    = item_q.segment_id;
			result.dispatch_size  = item_q.segment_size;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[tail_q] <= '{id: item_q.segment_id, size: item_q.segment_size};
		end
		if (cmd.issue_read) begin
			rd_q <= mem[head_q];
		end
		if (cmd.capture) begin
			item_q <= seg;
		end
		if (cmd.commit_direct || cmd.commit_pop) begin
			res_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_limit_q <= SIZE_LIMIT_RST;
			list_limit_q <= LIST_LIMIT_RST;
			delay_cap_q  <= DELAY_CAP_RST;
			dec_idle_q   <= 1'b1;
			total_q      <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			full_q       <= 1'b0;
			delay_q      <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SIZE_LIMIT: size_limit_q <= cfg_data;
					CFG_LIST_LIMIT: list_limit_q <= cfg_data[LIMIT_W-1:0];
					CFG_DELAY_CAP:  delay_cap_q  <= cfg_data[DELAY_W-1:0];
					default: begin
					end
				endcase
			end
			total_q <= total_d;
			count_q <= count_d;
			if (push) begin
				tail_q <= (tail_q == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + PW'(1);
			end
			if (cmd.commit_pop) begin
				head_q     <= (head_q == PW'(QUEUE_DEPTH - 1)) ? '0 : head_q + PW'(1);
				dec_idle_q <= 1'b0;
			end else if (cmd.commit_direct) begin
				dec_idle_q <= arrive ? 1'b0 : 1'b1;
			end
			if (do_eval) begin
				full_q  <= full_eval;
				delay_q <= delay_eval;
			end
			if (cmd.commit_direct || cmd.commit_pop) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

[hw/rtl/segment_dispatch_backpressure.sv]
// top level of the segment dispatch buffer with backpressure
// Segment descriptors arrive on the seg channel (func 0 = a segment arrives,
// func 1 = the decoder reports idle) and every request produces exactly one
// result on the res channel. An arrival is handed straight to the decoder when
// it is idle, otherwise it is queued and its size added to a byte total; an
// arrival that finds the queue holding QUEUE_DEPTH segments is discarded and
// flagged as dropped. An idle report pops the queue head and dispatches it.
// After each arrival or pop the buffer is full when the byte total exceeds
// size_limit or the queued count exceeds list_limit; while full the suggested
// delay counts up to delay_cap, otherwise it is 0. An idle report on an empty
// queue leaves full and delay as they were. An accepted request is captured,
// then committed to the result register from the execute state; a pop first
// passes a load state for the registered read of the queue memory, and the
// commit waits while the previous result stays stalled. The next request is
// taken the cycle after its result is registered, even while that result is
// still stalled, and none is taken earlier. Configuration writes
// (cfg_index 0 = size_limit, 1 = list_limit, 2 = delay_cap) take effect at
// once and belong only to idle periods. The queue memory needs no clearing.
module segment_dispatch_backpressure import sdb_pkg::*; #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// request channel
	input  logic                 seg_valid,
	output logic                 seg_stall,
	input  sdb_in_t              seg,
	// result channel
	output logic                 res_valid,
	input  logic                 res_stall,
	output sdb_out_t             res,
	// configuration write port
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	sdb_cmd_t  cmd;
	sdb_stat_t stat;

	// sequencing of capture, memory read and commit
	sdb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg_valid (seg_valid),
		.seg_stall (seg_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// queue, totals, evaluation and the result register
	sdb_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg       (seg),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule
